@@ rtl/fpba_pkg.sv @@
// Package for the fit-policy block allocator: codes, state type and default sizes.
package fpba_pkg;

   // Default sizes
   localparam int MAX_BLOCKS_DEF    = 16;
   localparam int CAPACITY_BITS_DEF = 16;

   // Request kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_ALLOC   = 2'd2;

   // Placement policies
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_ACK    = 2'd0;
   localparam logic [1:0] STATUS_GRANT  = 2'd1;
   localparam logic [1:0] STATUS_REFUSE = 2'd2;

   // Register indexes
   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_BLOCKS = 1'b1;

   // Reset values of the registers
   localparam logic [1:0] POLICY_RESET = POLICY_FIRST;
   localparam logic [4:0] BLOCKS_RESET = 5'd16;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/fpba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fit_policy_block_allocator_core.sv @@
// Top level of the fit-policy block allocator: sequencer, registers and capacity tables.
//
// The allocator holds an original and a working capacity for each of MAX_BLOCKS blocks in two
// small RAMs and serves one request at a time; req_ready is high only while it is idle. A load
// writes one block and then responds. A restart copies the original table into the working
// table through the RAM ports, one block a cycle. An allocate scans the first blocks_in_use
// blocks (saturated to MAX_BLOCKS) one per cycle through the working RAM's single read port and
// one shared comparator, then writes back the remainder, or stops the run when no block fits;
// when the run is already stopped it is refused without a scan. The block is ready again in the
// same cycle that rsp_valid rises. After reset a clearing pass zeroes both tables before the
// first request is taken; the configuration registers can be written during it. A finished
// response sits in an output register until the consumer takes it.
module fit_policy_block_allocator_core #(
   parameter int MAX_BLOCKS    = fpba_pkg::MAX_BLOCKS_DEF,
   parameter int CAPACITY_BITS = fpba_pkg::CAPACITY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_block_number,
   input  logic [15:0] req_amount,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_chosen_block,
   output logic [15:0] rsp_left_over,
   output logic [15:0] rsp_request_number,
   // configuration port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   import fpba_pkg::*;

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [8:0] MAX_WIDE = 9'(MAX_BLOCKS);

   // Registers
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]        limit_ff, limit_in;
   logic [CAPACITY_BITS-1:0] amount_ff, amount_in;
   logic                    found_ff, found_in;
   logic [CAPACITY_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]        pick_ff, pick_in;
   logic                    stopped_ff, stopped_in;
   logic [15:0]             count_ff, count_in;
   logic [1:0]              policy_ff, policy_in;
   logic [4:0]              blocks_ff, blocks_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [3:0]              res_chosen_ff, res_chosen_in;
   logic [15:0]             res_left_ff, res_left_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [3:0]              rsp_chosen_ff, rsp_chosen_in;
   logic [15:0]             rsp_left_ff, rsp_left_in;
   logic [15:0]             rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                     orig_we, work_we;
   logic [IDX_W-1:0]         orig_waddr, work_waddr;
   logic [CAPACITY_BITS-1:0] orig_wdata, work_wdata;
   logic [CAPACITY_BITS-1:0] orig_rdata, work_rdata;
   logic [IDX_W-1:0]         rd_addr;

   // Helpers
   logic                     req_fire;
   logic [31:0]              amount_wide;
   logic [CAPACITY_BITS-1:0] amount_cap;
   logic [8:0]               block_wide;
   logic [31:0]              block_ext;
   logic [8:0]               blocks_wide;
   logic [CAPACITY_BITS-1:0] remain;
   logic [31:0]              remain_wide;
   logic [31:0]              pick_wide;
   logic                     fits;
   logic                     better;

   assign req_fire    = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign amount_wide = {16'b0, req_amount};
   assign amount_cap  = amount_wide[CAPACITY_BITS-1:0];
   assign block_wide  = {5'b0, req_block_number};
   assign block_ext   = {28'b0, req_block_number};
   assign blocks_wide = {4'b0, blocks_ff};
   assign rd_addr     = idx_ff[IDX_W-1:0];
   assign remain      = best_ff - amount_ff;
   assign remain_wide = 32'(remain);
   assign pick_wide   = 32'(pick_ff);

   // Shared comparator path: does the block fit, and does it beat the current pick
   assign fits   = (work_rdata >= amount_ff);
   assign better = !found_ff
                || ((policy_ff == POLICY_BEST)  && (work_rdata < best_ff))
                || ((policy_ff == POLICY_WORST) && (work_rdata > best_ff));

   fpba_ram #(
      .WIDTH  (CAPACITY_BITS),
      .DEPTH  (MAX_BLOCKS),
      .ADDR_W (IDX_W)
   ) u_orig_ram (
      .clock (clock),
      .we    (orig_we),
      .waddr (orig_waddr),
      .wdata (orig_wdata),
      .raddr (rd_addr),
      .rdata (orig_rdata)
   );

   fpba_ram #(
      .WIDTH  (CAPACITY_BITS),
      .DEPTH  (MAX_BLOCKS),
      .ADDR_W (IDX_W)
   ) u_work_ram (
      .clock (clock),
      .we    (work_we),
      .waddr (work_waddr),
      .wdata (work_wdata),
      .raddr (rd_addr),
      .rdata (work_rdata)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
         count_ff     <= '0;
         policy_ff    <= POLICY_RESET;
         blocks_ff    <= BLOCKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         stopped_ff   <= stopped_in;
         count_ff     <= count_in;
         policy_ff    <= policy_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      limit_ff      <= limit_in;
      amount_ff     <= amount_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      res_status_ff <= res_status_in;
      res_chosen_ff <= res_chosen_in;
      res_left_ff   <= res_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      limit_in      = limit_ff;
      amount_in     = amount_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      stopped_in    = stopped_ff;
      count_in      = count_ff;
      policy_in     = policy_ff;
      blocks_in     = blocks_ff;
      res_status_in = res_status_ff;
      res_chosen_in = res_chosen_ff;
      res_left_in   = res_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_count_in  = rsp_count_ff;
      orig_we       = 1'b0;
      orig_waddr    = rd_addr;
      orig_wdata    = '0;
      work_we       = 1'b0;
      work_waddr    = rd_addr;
      work_wdata    = '0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY: policy_in = csr_wdata[1:0];
            CSR_BLOCKS: blocks_in = csr_wdata;
            default:    policy_in = policy_ff;
         endcase
      end

      unique case (state_ff)
         // zero both tables after reset
         ST_CLEAR: begin
            orig_we = 1'b1;
            work_we = 1'b1;
            idx_in  = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(MAX_BLOCKS - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               idx_in        = '0;
               found_in      = 1'b0;
               res_status_in = STATUS_ACK;
               res_chosen_in = '0;
               res_left_in   = '0;
               amount_in     = amount_cap;
               limit_in      = (blocks_wide > MAX_WIDE) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(blocks_wide);
               case (req_kind)
                  KIND_LOAD: begin
                     if (block_wide < MAX_WIDE) begin
                        orig_we    = 1'b1;
                        work_we    = 1'b1;
                        orig_waddr = block_ext[IDX_W-1:0];
                        work_waddr = block_ext[IDX_W-1:0];
                        orig_wdata = amount_cap;
                        work_wdata = amount_cap;
                     end
                     state_in = ST_DONE;
                  end
                  KIND_RESTART: begin
                     stopped_in = 1'b0;
                     count_in   = '0;
                     state_in   = ST_COPY;
                  end
                  KIND_ALLOC: begin
                     if (count_ff != 16'hFFFF) begin
                        count_in = count_ff + 16'd1;
                     end
                     if (stopped_ff) begin
                        res_status_in = STATUS_REFUSE;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // originals into the working table, each block read in the cycle before its write
         ST_COPY: begin
            if (idx_ff < CNT_W'(MAX_BLOCKS)) begin
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_addr;
            end
            if (pend_ff) begin
               work_we    = 1'b1;
               work_waddr = pend_idx_ff;
               work_wdata = orig_rdata;
            end else if (idx_ff >= CNT_W'(MAX_BLOCKS)) begin
               state_in = ST_DONE;
            end
         end

         // one block per cycle through the shared comparator
         ST_SCAN: begin
            if (idx_ff < limit_ff) begin
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_addr;
            end
            if (pend_ff) begin
               if (fits && better) begin
                  found_in = 1'b1;
                  best_in  = work_rdata;
                  pick_in  = pend_idx_ff;
               end
            end else if (idx_ff >= limit_ff) begin
               state_in = ST_UPDATE;
            end
         end

         // write back the remainder, or stop the run
         ST_UPDATE: begin
            if (found_ff) begin
               work_we       = 1'b1;
               work_waddr    = pick_ff;
               work_wdata    = remain;
               res_status_in = STATUS_GRANT;
               res_chosen_in = pick_wide[3:0];
               res_left_in   = remain_wide[15:0];
            end else begin
               stopped_in    = 1'b1;
               res_status_in = STATUS_REFUSE;
            end
            state_in = ST_DONE;
         end

         // hand the response to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_chosen_in = res_chosen_ff;
               rsp_left_in   = res_left_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chosen_block   = rsp_chosen_ff;
   assign rsp_left_over      = rsp_left_ff;
   assign rsp_request_number = rsp_count_ff;

   // A pending compare always refers to a block inside the search window
   a_pend_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff) |-> (CNT_W'(pend_idx_ff) < limit_ff))
      else $error("scan compare outside the searched blocks");

   // A held pick always fits the request
   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && found_ff) |-> (best_ff >= amount_ff))
      else $error("chosen block is smaller than the request");

   // A fresh refusal leaves the run stopped
   a_refuse_stops: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_status_ff == STATUS_REFUSE) |-> stopped_ff)
      else $error("refusal without stopping the run");

   // An allocate always leaves a nonzero request count
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == KIND_ALLOC) |=> (count_ff != 16'd0))
      else $error("allocate did not advance the request count");

endmodule

@@ bench/fpba_alloc_checker.sv @@
// Response checker for the fit-policy block allocator: tracks state, predicts and compares.
module fpba_alloc_checker #(
   parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_block_number,
   input  logic [15:0] req_amount,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [3:0]  rsp_chosen_block,
   input  logic [15:0] rsp_left_over,
   input  logic [15:0] rsp_request_number,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          grant_count,
   output int          refuse_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpba_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  chosen_block;
      logic [15:0] left_over;
      logic [15:0] request_number;
   } alloc_result_type;

   // Shadow copy of the allocator state and its registers
   logic [15:0]      original_cap [MAX_BLOCKS];
   logic [15:0]      working_cap [MAX_BLOCKS];
   logic             run_halted;
   logic [15:0]      alloc_count;
   logic [1:0]       fit_policy;
   logic [4:0]       search_len;
   alloc_result_type expected_q [$];
   int               mismatches;
   int               checked;
   int               grants;
   int               refusals;

   // Pick a block for a request of the given size; -1 when none fits
   function automatic int choose_block(logic [15:0] size);
      int limit;
      int pick;
      limit = (search_len > MAX_BLOCKS) ? MAX_BLOCKS : int'(search_len);
      pick = -1;
      for (int i = 0; i < limit; i++) begin
         if (working_cap[i] >= size) begin
            // ties keep the lower index, first fit never moves off its first hit
            if (pick < 0)
               pick = i;
            else if (fit_policy == POLICY_BEST && working_cap[i] < working_cap[pick])
               pick = i;
            else if (fit_policy == POLICY_WORST && working_cap[i] > working_cap[pick])
               pick = i;
         end
      end
      return pick;
   endfunction

   // Apply one request to the shadow state and return the response it should produce
   function automatic alloc_result_type apply_request(logic [1:0] kind, logic [3:0] blk,
                                                      logic [15:0] amount);
      alloc_result_type res;
      int pick;
      res = '0;
      res.status = STATUS_ACK;
      case (kind)
         KIND_LOAD: begin
            if (blk < MAX_BLOCKS) begin
               original_cap[blk] = amount;
               working_cap[blk] = amount;
            end
         end
         KIND_RESTART: begin
            for (int i = 0; i < MAX_BLOCKS; i++)
               working_cap[i] = original_cap[i];
            run_halted = 1'b0;
            alloc_count = '0;
         end
         default: begin
            // allocate: counts even when refused, saturates at all ones
            if (alloc_count != 16'hFFFF)
               alloc_count = alloc_count + 16'd1;
            pick = run_halted ? -1 : choose_block(amount);
            if (pick < 0) begin
               run_halted = 1'b1;
               res.status = STATUS_REFUSE;
            end else begin
               working_cap[pick] = working_cap[pick] - amount;
               res.status = STATUS_GRANT;
               res.chosen_block = 4'(pick);
               res.left_over = working_cap[pick];
            end
         end
      endcase
      res.request_number = alloc_count;
      return res;
   endfunction

   function automatic void report_field(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
   endfunction

   // Track registers, predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            original_cap[i] = '0;
            working_cap[i] = '0;
         end
         run_halted = 1'b0;
         alloc_count = '0;
         fit_policy = POLICY_RESET;
         search_len = BLOCKS_RESET;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_POLICY)
               fit_policy = csr_wdata[1:0];
            else
               search_len = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] response with none pending: status 0x%0h block 0x%0h",
                           $time, rsp_status, rsp_chosen_block);
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (rsp_status !== want.status)
                  report_field("status", want.status, rsp_status);
               if (rsp_chosen_block !== want.chosen_block)
                  report_field("chosen_block", want.chosen_block, rsp_chosen_block);
               if (rsp_left_over !== want.left_over)
                  report_field("left_over", want.left_over, rsp_left_over);
               if (rsp_request_number !== want.request_number)
                  report_field("request_number", want.request_number, rsp_request_number);
               if (want.status == STATUS_GRANT)
                  grants++;
               else if (want.status == STATUS_REFUSE)
                  refusals++;
            end
         end
         // the unused kind is swallowed without a response
         if (req_valid && req_ready &&
             (req_kind == KIND_LOAD || req_kind == KIND_RESTART || req_kind == KIND_ALLOC))
            expected_q.push_back(apply_request(req_kind, req_block_number, req_amount));
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
      checked_count <= checked;
      grant_count   <= grants;
      refuse_count  <= refusals;
   end

endmodule

@@ bench/fit_policy_block_allocator_core_test.sv @@
// Testbench top for the fit-policy block allocator: stimulus, idling modes and verdict.
module fit_policy_block_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fpba_pkg::*;

   localparam logic [1:0] KIND_SPARE        = 2'd3;
   localparam logic [1:0] POLICY_SPARE      = 2'd3;
   localparam int         SETTLE_CYCLES     = 40;
   localparam int         HOLD_CYCLES       = 300;
   localparam int         PHASE_REQUESTS    = 500;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [3:0]  req_block_number;
   logic [15:0] req_amount;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_chosen_block;
   logic [15:0] rsp_left_over;
   logic [15:0] rsp_request_number;
   logic        csr_we;
   logic        csr_index;
   logic [4:0]  csr_wdata;

   int   send_idle_pct;
   int   stall_pct;
   logic rsp_hold;
   int   sent_count;
   int   fail_count;
   int   pending_count;
   int   checked_count;
   int   grant_count;
   int   refuse_count;

   fit_policy_block_allocator_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_block_number   (req_block_number),
      .req_amount         (req_amount),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_left_over      (rsp_left_over),
      .rsp_request_number (rsp_request_number),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   fpba_alloc_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_block_number   (req_block_number),
      .req_amount         (req_amount),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_left_over      (rsp_left_over),
      .rsp_request_number (rsp_request_number),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count),
      .grant_count        (grant_count),
      .refuse_count       (refuse_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("fit_policy_block_allocator_core verification failed");
      $finish;
   end

   // Response side: random stalls, or a solid hold-off while rsp_hold is set
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request, with random idle cycles ahead of it, and wait until it is taken
   task automatic send_request(input logic [1:0] kind, input logic [3:0] blk,
                               input logic [15:0] amount);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_block_number = blk;
      req_amount = amount;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (kind != KIND_SPARE)
         sent_count++;
   endtask

   // Stop offering, wait for every response, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic reconfigure(input logic [1:0] pol, input logic [4:0] len);
      drain();
      write_csr(CSR_POLICY, {3'b000, pol});
      write_csr(CSR_BLOCKS, len);
   endtask

   // One allocation session: new settings, a few loads, a restart, then allocations
   task automatic run_session();
      int          pick;
      int          loads;
      int          allocs;
      logic [1:0]  pol;
      logic [4:0]  len;
      logic [15:0] size;
      pol = 2'($urandom_range(3));
      pick = $urandom_range(19);
      if (pick == 0)
         len = 5'd0;
      else if (pick < 3)
         len = 5'($urandom_range(17, 31));
      else
         len = 5'($urandom_range(1, 16));
      reconfigure(pol, len);
      loads = $urandom_range(1, 16);
      repeat (loads) begin
         size = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
         send_request(KIND_LOAD, 4'($urandom), size);
      end
      if ($urandom_range(7) != 0)
         send_request(KIND_RESTART, 4'($urandom), 16'($urandom));
      allocs = $urandom_range(4, 16);
      repeat (allocs) begin
         pick = $urandom_range(19);
         if (pick == 0) begin
            // noise: any kind, any fields
            send_request(2'($urandom), 4'($urandom), 16'($urandom));
         end else begin
            if (pick == 1)
               size = 16'd0;
            else if (pick < 5)
               size = 16'($urandom);
            else
               size = 16'($urandom_range(1, 600));
            send_request(KIND_ALLOC, 4'($urandom), size);
         end
      end
   endtask

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD;
      req_block_number = '0;
      req_amount = '0;
      csr_we = 1'b0;
      csr_index = CSR_POLICY;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      rsp_hold = 1'b0;
      sent_count = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, stop and restart, each policy, search length extremes
      reconfigure(POLICY_FIRST, 5'd16);
      send_request(KIND_ALLOC, 4'd0, 16'h0000);     // zero size fits an empty block
      send_request(KIND_ALLOC, 4'd9, 16'h0001);     // nothing fits, run stops
      send_request(KIND_ALLOC, 4'd0, 16'h0000);     // refused while stopped, still counted
      send_request(KIND_LOAD, 4'd0, 16'hFFFF);
      send_request(KIND_LOAD, 4'd15, 16'h8000);
      send_request(KIND_LOAD, 4'd7, 16'h00FF);
      send_request(KIND_LOAD, 4'd3, 16'h1234);
      send_request(KIND_SPARE, 4'd5, 16'hAAAA);     // unused kind, no response
      send_request(KIND_RESTART, 4'd0, 16'h0000);
      send_request(KIND_ALLOC, 4'd0, 16'h0100);
      reconfigure(POLICY_BEST, 5'd16);
      send_request(KIND_ALLOC, 4'd0, 16'h00F0);
      send_request(KIND_ALLOC, 4'd0, 16'h0010);
      reconfigure(POLICY_WORST, 5'd16);
      send_request(KIND_ALLOC, 4'd0, 16'h1000);
      send_request(KIND_ALLOC, 4'd0, 16'h0000);
      reconfigure(POLICY_SPARE, 5'd31);             // spare policy acts as first fit
      send_request(KIND_ALLOC, 4'd0, 16'h0200);
      reconfigure(POLICY_BEST, 5'd1);
      send_request(KIND_ALLOC, 4'd0, 16'h8000);
      reconfigure(POLICY_WORST, 5'd0);              // empty search refuses everything
      send_request(KIND_ALLOC, 4'd0, 16'h0000);
      send_request(KIND_LOAD, 4'd15, 16'h5555);     // load reports the running count
      send_request(KIND_RESTART, 4'hF, 16'hFFFF);
      reconfigure(POLICY_FIRST, 5'd17);
      send_request(KIND_ALLOC, 4'hF, 16'hFFFF);

      // Back-pressure: hold the response side off while requests keep coming
      drain();
      fork
         begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      repeat (12)
         send_request($urandom_range(1) ? KIND_ALLOC : KIND_LOAD, 4'($urandom),
                      16'($urandom_range(0, 3000)));

      // Random sessions under each idling mode
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 67;
            end
            default: begin
               send_idle_pct = 31;
               stall_pct = 31;
            end
         endcase
         target = sent_count + PHASE_REQUESTS;
         while (sent_count < target)
            run_session();
      end

      drain();
      $display("Sent %0d requests across four idling modes, a response hold-off,",
               sent_count);
      $display("all policies and search lengths 0..31; %0d responses (%0d grants, %0d refusals)",
               checked_count, grant_count, refuse_count);
      if (fail_count == 0)
         $display("fit_policy_block_allocator_core verification clean");
      else
         $display("fit_policy_block_allocator_core verification failed");
      $finish;
   end

endmodule
